// ----- rtl/pn2d_pkg.sv -----
// ----------------------------------------------------------------------------
// pn2d_pkg
// Shared constants for the 2D gradient noise pipeline.
// ----------------------------------------------------------------------------
package pn2d_pkg;

  localparam int COORD_W = 24;
  localparam int NOISE_W = 16;

  localparam int INT_BITS_DEF   = 12;
  localparam int FRAC_BITS_DEF  = 12;
  localparam int ANGLE_BITS_DEF = 10;

  localparam logic [31:0] HASH_M1 = 32'd3284157443;
  localparam logic [31:0] HASH_M2 = 32'd1911520717;
  localparam logic [31:0] HASH_M3 = 32'd2048419325;

  // rotator runs in Q2.28, angle in 2^-32 turn
  localparam int          CORDIC_STEPS = 16;
  localparam logic signed [31:0] CORDIC_GAIN_Q28 = 32'sd163008219;
  localparam logic signed [17:0] Q14_ONE = 18'sd16384;

  localparam logic signed [31:0] ATAN_TURNS [CORDIC_STEPS] = '{
    32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
    32'sd42667331,  32'sd21354465,  32'sd10679838,  32'sd5340245,
    32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
    32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861
  };

endpackage

// ----- rtl/perlin_noise_2d_top.sv -----
// ----------------------------------------------------------------------------
// perlin_noise_2d_top
// Streaming 2D gradient noise: one point in, one noise word out.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one point per word: unsigned
//   fixed-point x and y grid coordinates. Output channel (out_valid/out_ready)
//   carries one signed Q1.14 noise word per input word, in input order.
//   Throughput: one word per clock, sustained, as long as out_ready is high.
//   The pipeline is 19 register stages: input capture, three hash multiply
//   stages (32x32 low-half products), eight rotator stages (two
//   shift-add steps each), gradient fold, dot products, dot rounding, x blend
//   multiply, x blend round, y blend multiply, and the output register, which
//   takes the y blend round and clamp.
//   Stalls: when the output word is held (out_valid high, out_ready low) the
//   whole pipeline freezes and in_ready drops in the same cycle; nothing is
//   dropped or repeated. Empty stages advance freely otherwise.
//   Reset (rst_n low, synchronous) clears all stage valid bits; payload
//   registers are not reset.
// ----------------------------------------------------------------------------
module perlin_noise_2d_top
  import pn2d_pkg::*;
#(
  parameter int INT_BITS   = INT_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [COORD_W-1:0]        in_x_coord,
  input  logic [COORD_W-1:0]        in_y_coord,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [NOISE_W-1:0] out_noise_value
);

  // integer bits actually present in a 24-bit coordinate
  localparam int IW = (COORD_W - FRAC_BITS < INT_BITS) ? COORD_W - FRAC_BITS : INT_BITS;
  localparam int CSTG = CORDIC_STEPS / 2;
  localparam int PW   = FRAC_BITS + 17;   // dot product term
  localparam int BMW  = FRAC_BITS + 20;   // first blend product
  localparam int FMW  = FRAC_BITS + 21;   // final blend product

  localparam int S_HA  = 1;
  localparam int S_HB  = 2;
  localparam int S_HH  = 3;
  localparam int S_COR = 4;
  localparam int S_GRD = S_COR + CSTG;
  localparam int S_PRD = S_GRD + 1;
  localparam int S_DOT = S_PRD + 1;
  localparam int S_BM  = S_DOT + 1;
  localparam int S_LRP = S_BM + 1;
  localparam int S_FM  = S_LRP + 1;
  localparam int S_OUT = S_FM + 1;
  localparam int NST   = S_OUT + 1;

  localparam logic [31:0] ZMASK =
    32'h3FFF_FFFF & ~((32'd1 << (32 - ANGLE_BITS)) - 32'd1);

  logic en;
  logic vld_r [NST];

  // fraction bits ride along to the blend stages
  logic [FRAC_BITS-1:0] fx_r [S_BM];
  logic [FRAC_BITS-1:0] fy_r [S_FM];

  logic [IW-1:0] ix_r, iy_r, iy1_r;
  logic [31:0]   ha_r [2];
  logic [31:0]   a2_r [4];
  logic [31:0]   hb_r [4];
  logic [31:0]   hh_r [4];

  logic [1:0]         cq_r [CSTG][4];
  logic signed [31:0] cx_r [CSTG][4];
  logic signed [31:0] cy_r [CSTG][4];
  logic signed [31:0] cz_r [CSTG][4];

  logic [1:0]         cq_in [CSTG][4];
  logic signed [31:0] cx_in [CSTG][4];
  logic signed [31:0] cy_in [CSTG][4];
  logic signed [31:0] cz_in [CSTG][4];
  logic signed [31:0] cx_nxt [CSTG][4];
  logic signed [31:0] cy_nxt [CSTG][4];
  logic signed [31:0] cz_nxt [CSTG][4];

  logic signed [15:0]   gs_r [4], gc_r [4];
  logic signed [15:0]   gs_nxt [4], gc_nxt [4];
  logic signed [PW-1:0] ps_r [4], pc_r [4];
  logic signed [17:0]   n_r [4];
  logic signed [BMW-1:0] m0_r, m1_r;
  logic signed [17:0]   n00_r, n01_r;
  logic signed [18:0]   l0_r, l1_r;
  logic signed [FMW-1:0] mf_r;
  logic signed [18:0]   l0c_r;
  logic signed [NOISE_W-1:0] out_r;
  logic signed [NOISE_W-1:0] out_nxt;

  // whole pipe moves unless the output word is held
  assign en        = !vld_r[S_OUT] || out_ready;
  assign in_ready  = en;
  assign out_valid = vld_r[S_OUT];
  assign out_noise_value = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NST; k++) vld_r[k] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
      for (int k = 1; k < NST; k++) vld_r[k] <= vld_r[k-1];
    end
  end

  // rotator: two micro-rotations per stage
  always_comb begin
    logic signed [31:0] xv, yv, zv, nx;
    int sh;
    for (int c = 0; c < 4; c++) begin
      cq_in[0][c] = hh_r[c][31:30];
      cx_in[0][c] = CORDIC_GAIN_Q28;
      cy_in[0][c] = '0;
      cz_in[0][c] = $signed(hh_r[c] & ZMASK);
    end
    for (int k = 1; k < CSTG; k++) begin
      for (int c = 0; c < 4; c++) begin
        cq_in[k][c] = cq_r[k-1][c];
        cx_in[k][c] = cx_r[k-1][c];
        cy_in[k][c] = cy_r[k-1][c];
        cz_in[k][c] = cz_r[k-1][c];
      end
    end
    for (int k = 0; k < CSTG; k++) begin
      for (int c = 0; c < 4; c++) begin
        xv = cx_in[k][c];
        yv = cy_in[k][c];
        zv = cz_in[k][c];
        for (int j = 0; j < 2; j++) begin
          sh = 2 * k + j;
          if (!zv[31]) begin
            nx = xv - (yv >>> sh);
            yv = yv + (xv >>> sh);
            zv = zv - ATAN_TURNS[sh];
          end else begin
            nx = xv + (yv >>> sh);
            yv = yv - (xv >>> sh);
            zv = zv + ATAN_TURNS[sh];
          end
          xv = nx;
        end
        cx_nxt[k][c] = xv;
        cy_nxt[k][c] = yv;
        cz_nxt[k][c] = zv;
      end
    end
  end

  // round to Q1.14, clamp, quadrant fold
  always_comb begin
    logic signed [17:0] cr, sr;
    logic signed [15:0] cc, ss;
    for (int c = 0; c < 4; c++) begin
      cr = 18'((cx_r[CSTG-1][c] + 32'sd8192) >>> 14);
      sr = 18'((cy_r[CSTG-1][c] + 32'sd8192) >>> 14);
      cc = (cr > Q14_ONE) ? 16'(Q14_ONE) : ((cr < -Q14_ONE) ? 16'(-Q14_ONE) : 16'(cr));
      ss = (sr > Q14_ONE) ? 16'(Q14_ONE) : ((sr < -Q14_ONE) ? 16'(-Q14_ONE) : 16'(sr));
      case (cq_r[CSTG-1][c])
        2'd0:    begin gs_nxt[c] = ss;  gc_nxt[c] = cc;  end
        2'd1:    begin gs_nxt[c] = cc;  gc_nxt[c] = -ss; end
        2'd2:    begin gs_nxt[c] = -ss; gc_nxt[c] = -cc; end
        default: begin gs_nxt[c] = -cc; gc_nxt[c] = ss;  end
      endcase
    end
  end

  // final blend and clamp
  always_comb begin
    logic signed [FMW:0] rnd;
    logic signed [20:0]  v;
    rnd = ({mf_r[FMW-1], mf_r} + (FMW+1)'(1 << (FRAC_BITS - 1))) >>> FRAC_BITS;
    v   = 21'(l0c_r) + 21'(rnd);
    if (v > 21'sd32767)       out_nxt = 16'sh7FFF;
    else if (v < -21'sd32768) out_nxt = 16'sh8000;
    else                      out_nxt = 16'(v);
  end

  always_ff @(posedge clk) begin
    logic signed [FRAC_BITS:0] dx, dy;
    logic signed [PW:0]        sum;
    logic signed [18:0]        d0, d1;
    logic signed [19:0]        dl;
    logic signed [BMW:0]       r0, r1;
    if (en) begin
      // capture
      fx_r[0] <= in_x_coord[FRAC_BITS-1:0];
      fy_r[0] <= in_y_coord[FRAC_BITS-1:0];
      ix_r    <= in_x_coord[FRAC_BITS +: IW];
      iy_r    <= in_y_coord[FRAC_BITS +: IW];
      for (int k = 1; k < S_BM; k++) fx_r[k] <= fx_r[k-1];
      for (int k = 1; k < S_FM; k++) fy_r[k] <= fy_r[k-1];

      // hash round 1: a = cx * M1 for both x corners
      ha_r[0] <= 32'(32'(ix_r) * HASH_M1);
      ha_r[1] <= 32'((32'(ix_r) + 32'd1) * HASH_M1);
      iy1_r   <= iy_r;

      // hash round 2 (corner c: bit 0 selects x+1, bit 1 selects y+1)
      for (int c = 0; c < 4; c++) begin
        a2_r[c] <= ha_r[c % 2];
        hb_r[c] <= 32'(((32'(iy1_r) + 32'(c / 2)) ^
                        {ha_r[c % 2][15:0], ha_r[c % 2][31:16]}) * HASH_M2);
      end

      // hash round 3
      for (int c = 0; c < 4; c++)
        hh_r[c] <= 32'((a2_r[c] ^ {hb_r[c][15:0], hb_r[c][31:16]}) * HASH_M3);

      for (int k = 0; k < CSTG; k++) begin
        for (int c = 0; c < 4; c++) begin
          cq_r[k][c] <= cq_in[k][c];
          cx_r[k][c] <= cx_nxt[k][c];
          cy_r[k][c] <= cy_nxt[k][c];
          cz_r[k][c] <= cz_nxt[k][c];
        end
      end

      for (int c = 0; c < 4; c++) begin
        gs_r[c] <= gs_nxt[c];
        gc_r[c] <= gc_nxt[c];
      end

      // offsets: fx - 1.0 is {1, fx} in two's complement
      for (int c = 0; c < 4; c++) begin
        dx = $signed({c[0], fx_r[S_PRD-1]});
        dy = $signed({c[1], fy_r[S_PRD-1]});
        ps_r[c] <= PW'(dx * gs_r[c]);
        pc_r[c] <= PW'(dy * gc_r[c]);
      end

      for (int c = 0; c < 4; c++) begin
        sum = (PW+1)'(ps_r[c]) + (PW+1)'(pc_r[c]) + (PW+1)'(1 << (FRAC_BITS - 1));
        n_r[c] <= 18'(sum >>> FRAC_BITS);
      end

      // blend along x
      d0 = 19'(n_r[1]) - 19'(n_r[0]);
      d1 = 19'(n_r[3]) - 19'(n_r[2]);
      m0_r  <= BMW'($signed({1'b0, fx_r[S_BM-1]}) * d0);
      m1_r  <= BMW'($signed({1'b0, fx_r[S_BM-1]}) * d1);
      n00_r <= n_r[0];
      n01_r <= n_r[2];

      r0 = ({m0_r[BMW-1], m0_r} + (BMW+1)'(1 << (FRAC_BITS - 1))) >>> FRAC_BITS;
      r1 = ({m1_r[BMW-1], m1_r} + (BMW+1)'(1 << (FRAC_BITS - 1))) >>> FRAC_BITS;
      l0_r <= 19'(n00_r) + 19'(r0);
      l1_r <= 19'(n01_r) + 19'(r1);

      // blend along y
      dl = 20'(l1_r) - 20'(l0_r);
      mf_r  <= FMW'($signed({1'b0, fy_r[S_FM-1]}) * dl);
      l0c_r <= l0_r;

      out_r <= out_nxt;
    end
  end

endmodule

// ----- rtl/pn2d_checker.sv -----
// ----------------------------------------------------------------------------
// pn2d_checker
// Port-level checks for the noise pipeline, bound to the top level.
// ----------------------------------------------------------------------------
module pn2d_checker
  import pn2d_pkg::*;
(
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic signed [NOISE_W-1:0] out_noise_value
);

  // held output word stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_noise_value))
    else $error("output word changed while stalled");

  // empty output stage never blocks input
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output");

  // stalled output freezes intake
  a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken during output stall");

  // reset empties the pipe
  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("output valid right after reset");

endmodule

bind perlin_noise_2d_top pn2d_checker u_pn2d_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_noise_value (out_noise_value)
);

// ----- verif/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the streaming 2D gradient noise pipeline. A local
// predictor (corner hash, integer rotator, dot products, bilinear blend)
// queues the expected noise word for each accepted point; a checker process
// compares every output word against the oldest expected one.
// ----------------------------------------------------------------------------
module tb_top
  import pn2d_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IB = INT_BITS_DEF;
  localparam int FB = FRAC_BITS_DEF;
  localparam int AB = ANGLE_BITS_DEF;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [COORD_W-1:0] in_x_coord = '0;
  logic [COORD_W-1:0] in_y_coord = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [NOISE_W-1:0] out_noise_value;

  perlin_noise_2d_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_x_coord(in_x_coord), .in_y_coord(in_y_coord),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_noise_value(out_noise_value)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic signed [NOISE_W-1:0] noise_expected[$];
  int mismatches = 0;
  int unexpected = 0;
  bit quiet_mode = 1'b0;   // no random idling on either side
  int hold_cycles = 0;     // forced receiver hold-off, in cycles

  // ---------------- predictor ----------------
  function automatic longint sra64(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint rnd_shift(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic logic [31:0] rot_half(logic [31:0] v);
    return {v[15:0], v[31:16]};
  endfunction

  function automatic logic [31:0] lattice_hash(logic [31:0] cx, logic [31:0] cy);
    logic [31:0] a;
    logic [31:0] b;
    a = cx * HASH_M1;
    b = cy ^ rot_half(a);
    b = b * HASH_M2;
    a = a ^ rot_half(b);
    return a * HASH_M3;
  endfunction

  // unit gradient (sin, cos) in Q1.14 for an angle in 2^-32 turn
  task automatic unit_gradient(input logic [31:0] phi, output longint gs,
                               output longint gc);
    longint x, y, z, nx, s, c;
    logic [1:0] quad;
    quad = phi[31:30];
    z = longint'(phi[29:0]);
    x = longint'(CORDIC_GAIN_Q28);
    y = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      if (z >= 0) begin
        nx = x - sra64(y, i);
        y = y + sra64(x, i);
        z = z - longint'(ATAN_TURNS[i]);
      end else begin
        nx = x + sra64(y, i);
        y = y - sra64(x, i);
        z = z + longint'(ATAN_TURNS[i]);
      end
      x = nx;
    end
    c = clip(rnd_shift(x, 14), -16384, 16384);
    s = clip(rnd_shift(y, 14), -16384, 16384);
    case (quad)
      2'd0: begin gs = s;  gc = c;  end
      2'd1: begin gs = c;  gc = -s; end
      2'd2: begin gs = -s; gc = -c; end
      default: begin gs = -c; gc = s; end
    endcase
  endtask

  task automatic corner_term(input logic [31:0] cx, input logic [31:0] cy,
                             input longint dx, input longint dy,
                             output longint term);
    logic [31:0] h;
    longint gs, gc;
    h = lattice_hash(cx, cy);
    h = (h >> (32 - AB)) << (32 - AB);
    unit_gradient(h, gs, gc);
    term = rnd_shift(dx * gs + dy * gc, FB);
  endtask

  function automatic longint lerp_q(longint a, longint b, longint t);
    return a + rnd_shift(t * (b - a), FB);
  endfunction

  task automatic predict_noise(input logic [COORD_W-1:0] xc,
                               input logic [COORD_W-1:0] yc,
                               output logic signed [NOISE_W-1:0] nv);
    logic [31:0] ix, iy;
    longint fx, fy, one, n00, n10, n01, n11, l0, l1, v;
    one = longint'(1) << FB;
    ix = 32'((xc >> FB) & ((1 << IB) - 1));
    iy = 32'((yc >> FB) & ((1 << IB) - 1));
    fx = longint'(xc & ((1 << FB) - 1));
    fy = longint'(yc & ((1 << FB) - 1));
    corner_term(ix, iy, fx, fy, n00);
    corner_term(ix + 1, iy, fx - one, fy, n10);
    corner_term(ix, iy + 1, fx, fy - one, n01);
    corner_term(ix + 1, iy + 1, fx - one, fy - one, n11);
    l0 = lerp_q(n00, n10, fx);
    l1 = lerp_q(n01, n11, fx);
    v = clip(lerp_q(l0, l1, fy), -32768, 32767);
    nv = NOISE_W'(v);
  endtask

  // ---------------- driver ----------------
  // valid drops only while idling, so back-to-back words keep it high
  task automatic send_point(input logic [COORD_W-1:0] xc,
                            input logic [COORD_W-1:0] yc);
    logic signed [NOISE_W-1:0] nv;
    while (!quiet_mode && $urandom_range(99) < 36) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_x_coord <= xc;
    in_y_coord <= yc;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_noise(xc, yc, nv);
    noise_expected.push_back(nv);
  endtask

  // receiver: random idling, or a counted hold-off when requested
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= quiet_mode ? 1'b1 : ($urandom_range(99) >= 36);
    end
  end

  // checker: each output word against the oldest expected word
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (noise_expected.size() == 0) begin
        unexpected++;
        if (mismatches + unexpected <= 10)
          $display("unexpected word %0d", out_noise_value);
      end else begin
        logic signed [NOISE_W-1:0] e;
        e = noise_expected.pop_front();
        if (e !== out_noise_value) begin
          mismatches++;
          if (mismatches + unexpected <= 10)
            $display("noise mismatch: expected %0d actual %0d", e, out_noise_value);
        end
      end
    end
  end

  function automatic logic [COORD_W-1:0] rand_coord();
    case ($urandom_range(3))
      0: return COORD_W'($urandom_range(4095));           // first cell row/col
      1: return COORD_W'($urandom) | 24'hFFF000;          // top cells
      default: return COORD_W'($urandom);
    endcase
  endfunction

  // ---------------- tests ----------------
  task automatic test_directed();
    logic [COORD_W-1:0] pts[$];
    pts = '{24'h000000, 24'hFFFFFF, 24'h000FFF, 24'h001000, 24'hFFF000,
            24'h800800, 24'h555555, 24'hAAAAAA, 24'h000001, 24'h7FFFFF};
    foreach (pts[i]) send_point(pts[i], pts[(i * 3) % pts.size()]);
    // top lattice cell on each axis in turn, then mid-cell points in the top and first cells
    send_point(24'hFFFFFF, 24'h000000);
    send_point(24'h000000, 24'hFFFFFF);
    send_point(24'hFFF800, 24'hFFF800);
    send_point(24'h000800, 24'h000800);
  endtask

  task automatic test_back_to_back();
    quiet_mode = 1'b1;
    repeat (60) send_point(rand_coord(), rand_coord());
    quiet_mode = 1'b0;
  endtask

  task automatic test_random();
    repeat (420) send_point(rand_coord(), rand_coord());
  endtask

  // receiver stalls long while the sender keeps offering: pipeline fills
  task automatic test_backpressure();
    hold_cycles = 80;
    quiet_mode = 1'b1;
    repeat (60) send_point(rand_coord(), rand_coord());
    quiet_mode = 1'b0;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_back_to_back();
    test_backpressure();
    test_random();
    in_valid <= 1'b0;
    while (noise_expected.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0 && unexpected == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("tb_top: FAIL");
    $finish;
  end
endmodule
